/* design/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and the ordering function of the sorted queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int OCC_W = 5;

    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [OCC_W-1:0]        t_occ;
    typedef logic signed [VAL_W-1:0] t_val;

    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic ORDER_MIN = 1'b0;

    // Per-cell control for one cycle.
    typedef struct packed {
        logic enq;
        logic deq;
        logic occ;
        logic tail;
        logic order;
        t_val value;
    } t_cell_ctrl;

    // True when a stored entry must move behind an incoming value.
    function automatic logic yields(input t_val existing, input t_val incoming,
                                    input logic order);
        if (order == ORDER_MIN) begin
            return existing > incoming;
        end
        return incoming > existing;
    endfunction

endpackage

/* design/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of signed 32-bit values held sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (i_cmd, i_value) is taken at a clock edge where start is
//   high and busy is low. busy stays low: one command per clock is taken.
//   Every cell compares its value with the incoming one at once, and the
//   whole chain shifts in the same cycle.
//   The result word (o_head_value, o_status, o_occupancy) appears the cycle
//   after acceptance and is valid for exactly one cycle while o_done is high.
//   Throughput 1 word per cycle. The receiver cannot stall.
//   Order is set by i_cfg_data when i_cfg_we is high: 0 smallest at head,
//   1 largest at head. Write it only while idle.
//   Reset (i_rst_n low, synchronous) empties the queue, clears the order
//   register and drops any pending result. Cell contents are not cleared.
//   A full enqueue returns status full; dequeue or peek on an empty queue
//   returns -1 with status empty.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_value,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    output logic               o_done,
    output logic signed [31:0] o_head_value,
    output logic [1:0]         o_status,
    output logic [4:0]         o_occupancy
);

    localparam int Depth = spq_pkg::DEPTH;

    spq_pkg::t_cnt r_count;
    spq_pkg::t_cnt n_count;
    logic          r_order;
    logic          r_done;
    spq_pkg::t_val r_head;
    logic [1:0]    r_status;
    spq_pkg::t_occ r_occ;

    spq_pkg::t_val n_head;
    logic [1:0]    n_status;
    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          do_enq;
    logic          do_deq;

    spq_pkg::t_val value_q [Depth];
    logic          yield_q [Depth];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = r_count == spq_pkg::t_cnt'(Depth);
    assign is_empty = r_count == '0;
    assign do_enq   = accept && i_cmd == spq_pkg::CMD_ENQ && !is_full;
    assign do_deq   = accept && i_cmd == spq_pkg::CMD_DEQ && !is_empty;

    genvar k;
    generate
        for (k = 0; k < Depth; k++) begin : g_cell
            spq_pkg::t_cell_ctrl ctrl;
            spq_pkg::t_val       left_value;
            logic                left_yield;
            spq_pkg::t_val       right_value;

            assign ctrl.enq   = do_enq;
            assign ctrl.deq   = do_deq;
            assign ctrl.occ   = r_count > spq_pkg::t_cnt'(k);
            assign ctrl.tail  = r_count == spq_pkg::t_cnt'(k);
            assign ctrl.order = r_order;
            assign ctrl.value = i_value;

            if (k == 0) begin : g_first
                assign left_value = i_value;
                assign left_yield = 1'b0;
            end else begin : g_mid
                assign left_value = value_q[k-1];
                assign left_yield = yield_q[k-1];
            end

            if (k == Depth - 1) begin : g_last
                assign right_value = value_q[k];
            end else begin : g_inner
                assign right_value = value_q[k+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (ctrl),
                .i_left_value  (left_value),
                .i_left_yield  (left_yield),
                .i_right_value (right_value),
                .o_value       (value_q[k]),
                .o_yield       (yield_q[k])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_head   = '0;
        n_status = spq_pkg::ST_OK;
        case (i_cmd)
            spq_pkg::CMD_ENQ: begin
                if (is_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK: begin
                if (is_empty) begin
                    n_head   = '1;
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_head = value_q[0];
                    if (i_cmd == spq_pkg::CMD_DEQ) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_order <= spq_pkg::ORDER_MIN;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_order <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head   <= n_head;
            r_status <= n_status;
            r_occ    <= spq_pkg::t_occ'(n_count);
        end
    end

    assign o_done       = r_done;
    assign o_head_value = r_head;
    assign o_status     = r_status;
    assign o_occupancy  = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::t_cnt'(Depth))
        else $error("count above depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted word produced no result");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == spq_pkg::ST_FULL |-> o_occupancy == spq_pkg::t_occ'(Depth))
        else $error("full status with queue not full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == spq_pkg::ST_EMPTY |-> o_occupancy == '0 && o_head_value == -1)
        else $error("empty status with bad result");

endmodule

/* design/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value, shifts with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_val       i_left_value,
    input  logic                i_left_yield,
    input  spq_pkg::t_val       i_right_value,
    output spq_pkg::t_val       o_value,
    output logic                o_yield
);

    spq_pkg::t_val r_value;
    spq_pkg::t_val n_value;

    assign o_value = r_value;
    assign o_yield = i_ctrl.occ && spq_pkg::yields(r_value, i_ctrl.value, i_ctrl.order);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.enq) begin
            if (i_left_yield) begin
                n_value = i_left_value;
            end else if (o_yield || i_ctrl.tail) begin
                n_value = i_ctrl.value;
            end
        end else if (i_ctrl.deq) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_priority_queue. A small class mirrors the
// sorted store and the order register, predicts one result word per accepted
// command word and checks every o_done word against it. Stimulus is a
// directed opener followed by phases of random fill, drain and mixed traffic,
// with the queue drained and the order flipped between phases.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_NONE     = 2'd3;
    localparam logic       ORDER_MAX    = 1'b1;
    localparam int         LIMIT_CYCLES = 300000;
    localparam int         PHASES       = 8;
    localparam int         PHASE_WORDS  = 210;
    localparam int         MAX_REPORTS  = 10;

    typedef struct {
        spq_pkg::t_val head;
        logic [1:0]    status;
        spq_pkg::t_occ occ;
    } t_result;

    class pq_mirror;
        spq_pkg::t_val slots[spq_pkg::DEPTH];
        int            stored;
        logic          order;
        t_result       due_q[$];
        int            errors;
        int            checked;
        int            cmd_seen[4];
        int            full_hits;
        int            empty_hits;

        function new();
            stored = 0;
            order  = spq_pkg::ORDER_MIN;
            errors = 0;
            checked = 0;
            full_hits = 0;
            empty_hits = 0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
        endfunction

        function bit moves_back(spq_pkg::t_val existing, spq_pkg::t_val incoming);
            if (order == spq_pkg::ORDER_MIN) begin
                return existing > incoming;
            end
            return incoming > existing;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        // Accepted command word: update the store and queue up its result.
        function void apply_cmd(logic [1:0] cmd, spq_pkg::t_val v);
            t_result r;
            int      k;
            r.head   = '0;
            r.status = spq_pkg::ST_OK;
            cmd_seen[cmd]++;
            case (cmd)
                spq_pkg::CMD_ENQ: begin
                    if (stored >= spq_pkg::DEPTH) begin
                        r.status = spq_pkg::ST_FULL;
                        full_hits++;
                    end else begin
                        k = stored;
                        while (k > 0 && moves_back(slots[k-1], v)) begin
                            slots[k] = slots[k-1];
                            k--;
                        end
                        slots[k] = v;
                        stored++;
                    end
                end
                spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK: begin
                    if (stored == 0) begin
                        r.head   = '1;
                        r.status = spq_pkg::ST_EMPTY;
                        empty_hits++;
                    end else begin
                        r.head = slots[0];
                        if (cmd == spq_pkg::CMD_DEQ) begin
                            for (k = 1; k < stored; k++) slots[k-1] = slots[k];
                            stored--;
                        end
                    end
                end
                default: ;
            endcase
            r.occ = spq_pkg::t_occ'(stored);
            due_q.push_back(r);
        endfunction

        function void check_result(spq_pkg::t_val head, logic [1:0] status,
                                   spq_pkg::t_occ occ);
            t_result e;
            if (due_q.size() == 0) begin
                flag($sformatf("result word with nothing pending: head %0d status %0d occ %0d",
                               head, status, occ));
                return;
            end
            e = due_q.pop_front();
            checked++;
            if (head !== e.head)
                flag($sformatf("head exp %0d got %0d", e.head, head));
            if (status !== e.status)
                flag($sformatf("status exp %0d got %0d", e.status, status));
            if (occ !== e.occ)
                flag($sformatf("occupancy exp %0d got %0d", e.occ, occ));
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic [1:0]         i_cmd      = spq_pkg::CMD_ENQ;
    logic signed [31:0] i_value    = '0;
    logic               i_cfg_we   = 1'b0;
    logic               i_cfg_data = spq_pkg::ORDER_MIN;
    logic               busy;
    logic               o_done;
    logic signed [31:0] o_head_value;
    logic [1:0]         o_status;
    logic [4:0]         o_occupancy;

    pq_mirror mirror = new();
    int       cycles = 0;

    sorted_priority_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_head_value (o_head_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            mirror.apply_cmd(i_cmd, i_value);
        end
        if (i_rst_n && o_done) begin
            mirror.check_result(o_head_value, o_status, o_occupancy);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, mirror.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic spq_pkg::t_val pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 30) return spq_pkg::t_val'(int'($urandom_range(8)) - 4);
        if (r < 40) begin
            case ($urandom_range(3))
                0: return spq_pkg::t_val'(32'h7FFF_FFFF);
                1: return spq_pkg::t_val'(32'h8000_0000);
                2: return spq_pkg::t_val'(32'h0000_0000);
                default: return spq_pkg::t_val'(32'hFFFF_FFFF);
            endcase
        end
        return spq_pkg::t_val'($urandom);
    endfunction

    // mix 0 leans to fill, 1 to drain, 2 balanced
    function automatic logic [1:0] pick_cmd(int mix);
        int r;
        int enq_pct;
        int deq_pct;
        r = $urandom_range(99);
        enq_pct = (mix == 0) ? 65 : (mix == 1) ? 30 : 45;
        deq_pct = (mix == 0) ? 85 : (mix == 1) ? 80 : 85;
        if (r < enq_pct) return spq_pkg::CMD_ENQ;
        if (r < deq_pct) return spq_pkg::CMD_DEQ;
        if (r < 97) return spq_pkg::CMD_PEEK;
        return CMD_NONE;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // start stays high on return; the caller sends again or lowers it
    task automatic send_word(input logic [1:0] c, input spq_pkg::t_val v);
        start   <= 1'b1;
        i_cmd   <= c;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // empty the store first so the new order starts from a sorted array
    task automatic set_order(input logic mode);
        int n;
        wait_drained();
        n = mirror.stored;
        repeat (n) begin
            send_word(spq_pkg::CMD_DEQ, pick_value());
            hold_off(pick_gap());
        end
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mirror.order = mode;
    endtask

    initial begin
        int mix;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, extremes, ties, fill to full, reject
        send_word(spq_pkg::CMD_PEEK, spq_pkg::t_val'(32'h0));
        send_word(spq_pkg::CMD_DEQ, spq_pkg::t_val'(32'h0));
        send_word(CMD_NONE, spq_pkg::t_val'(32'hFFFF_FFFF));
        send_word(spq_pkg::CMD_ENQ, spq_pkg::t_val'(32'h7FFF_FFFF));
        send_word(spq_pkg::CMD_ENQ, spq_pkg::t_val'(32'h8000_0000));
        send_word(spq_pkg::CMD_ENQ, spq_pkg::t_val'(32'h0));
        send_word(spq_pkg::CMD_ENQ, spq_pkg::t_val'(32'hFFFF_FFFF));
        send_word(spq_pkg::CMD_ENQ, spq_pkg::t_val'(32'h0));
        send_word(spq_pkg::CMD_PEEK, spq_pkg::t_val'(32'h5555_5555));
        send_word(CMD_NONE, spq_pkg::t_val'(32'hAAAA_AAAA));
        for (int i = 0; i < 11; i++) begin
            send_word(spq_pkg::CMD_ENQ, spq_pkg::t_val'(i - 5));
        end
        send_word(spq_pkg::CMD_ENQ, spq_pkg::t_val'(32'h1234_5678));
        send_word(spq_pkg::CMD_DEQ, spq_pkg::t_val'(32'h0));
        send_word(spq_pkg::CMD_PEEK, spq_pkg::t_val'(32'h0));
        hold_off(1);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_order(ph[0] ? spq_pkg::ORDER_MIN : ORDER_MAX);
            mix = ph % 3;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                send_word(pick_cmd(mix), pick_value());
                hold_off(pick_gap());
            end
        end

        wait_drained();
        if (mirror.pending() != 0) begin
            mirror.flag($sformatf("%0d results never arrived", mirror.pending()));
        end

        $display("words: %0d enqueue, %0d dequeue, %0d peek, %0d unused; %0d results checked",
                 mirror.cmd_seen[spq_pkg::CMD_ENQ], mirror.cmd_seen[spq_pkg::CMD_DEQ],
                 mirror.cmd_seen[spq_pkg::CMD_PEEK], mirror.cmd_seen[CMD_NONE],
                 mirror.checked);
        $display("full rejects %0d, empty reads %0d, both orders, %0d errors",
                 mirror.full_hits, mirror.empty_hits, mirror.errors);
        if (mirror.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
